>>> hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Shared types, action and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int DTQ_CAPACITY = 64;
    localparam int DTQ_MAX_OUT  = 64;
    localparam int DTQ_NW       = $clog2(DTQ_MAX_OUT + 1);

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_EXPIRE = 2'd3;

    localparam logic [2:0] ST_ADDED        = 3'd0;
    localparam logic [2:0] ST_CANCELLED    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [2:0] ST_FULL         = 3'd3;
    localparam logic [2:0] ST_NEXT_TIME    = 3'd4;
    localparam logic [2:0] ST_NO_TIMERS    = 3'd5;
    localparam logic [2:0] ST_EXPIRED      = 3'd6;
    localparam logic [2:0] ST_NONE_EXPIRED = 3'd7;

    localparam logic [30:0] REM_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] tag;
        logic [31:0] timeout_ms;
        logic        has_handler;
        logic [47:0] now_ms;
    } dtq_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] expired_tag;
        logic [30:0] remaining_ms;
        logic        last;
    } dtq_out_t;

    typedef struct packed {
        logic [47:0] deadline;
        logic [15:0] tag;
    } dtq_slot_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_FLUSH
    } dtq_state_t;

endpackage

>>> hw/rtl/deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// Deadline timer queue
// Tag-keyed one-shot timer store with add, cancel, query and expire.
// ----------------------------------------------------------------------------
// Add, cancel and query: one full scan pass, then the result is offered once
// the output register can take it, and the next input is taken in idle.
// Expire: one pass per timer removed and one more pass that finds nothing due
// (skipped once the limit of reported expiries is reached), then the final result.
// Each pass is a full scan of the slot memory through its single read port.
// Synchronous reset clears all slot flags at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int CAPACITY = dtq_pkg::DTQ_CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dtq_pkg::dtq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dtq_pkg::dtq_out_t m_data
);
    import dtq_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    logic      res_valid;
    logic      res_ready;
    dtq_out_t  res_data;
    logic      rd_en;
    logic [IW-1:0] rd_addr;
    dtq_slot_t rd_data;
    logic      wr_en;
    logic [IW-1:0] wr_addr;
    dtq_slot_t wr_data;

    logic     out_vld_reg, out_vld_next;
    dtq_out_t out_data_reg, out_data_next;

    dtq_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    dtq_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The output register takes a new result whenever it is empty or draining.
    assign res_ready = !out_vld_reg || m_ready;

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (res_valid) begin
            out_vld_next  = 1'b1;
            out_data_next = res_data;
        end else if (m_ready) begin
            out_vld_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

>>> hw/rtl/dtq_mem.sv
// ----------------------------------------------------------------------------
// Deadline timer queue slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dtq_mem #(
    parameter int DEPTH = dtq_pkg::DTQ_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  dtq_pkg::dtq_slot_t wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output dtq_pkg::dtq_slot_t rd_data
);
    import dtq_pkg::*;

    dtq_slot_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// Deadline timer queue controller
// Scans the slot memory once per pass and applies each action at its end.
// ----------------------------------------------------------------------------
module dtq_ctrl #(
    parameter int CAPACITY = dtq_pkg::DTQ_CAPACITY,
    parameter int IW       = $clog2(CAPACITY)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dtq_pkg::dtq_in_t   s_data,
    output logic               res_valid,
    input  logic               res_ready,
    output dtq_pkg::dtq_out_t  res_data,
    output logic               rd_en,
    output logic [IW-1:0]      rd_addr,
    input  dtq_pkg::dtq_slot_t rd_data,
    output logic               wr_en,
    output logic [IW-1:0]      wr_addr,
    output dtq_pkg::dtq_slot_t wr_data
);
    import dtq_pkg::*;

    dtq_state_t state_reg, state_next;
    dtq_in_t    item_reg, item_next;
    logic [IW:0] cnt_reg, cnt_next;
    logic        rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CAPACITY-1:0] rep_reg, rep_next;
    logic [CAPACITY-1:0] canc_reg, canc_next;
    logic        full_reg, full_next;
    logic        hit_reg, hit_next;
    logic [IW-1:0] sel_reg, sel_next;
    logic [47:0] best_dl_reg, best_dl_next;
    logic [15:0] best_tag_reg, best_tag_next;
    logic        pend_vld_reg, pend_vld_next;
    logic [15:0] pend_tag_reg, pend_tag_next;
    logic [DTQ_NW-1:0] n_reg, n_next;

    logic        scan_done;
    logic        due;
    logic        reported;
    logic        at_limit;
    logic [48:0] dl_sum;
    logic [47:0] dl_sat;
    logic [47:0] diff;
    logic [30:0] rem;

    assign scan_done = rd_vld_reg && (rd_idx_reg == IW'(CAPACITY - 1));
    assign due       = hit_reg && (best_dl_reg <= item_reg.now_ms);
    assign reported  = due && rep_reg[sel_reg];
    assign at_limit  = (n_reg + DTQ_NW'(1)) == DTQ_NW'(DTQ_MAX_OUT);
    assign dl_sum    = {1'b0, item_reg.now_ms} + {17'b0, item_reg.timeout_ms};
    assign dl_sat    = dl_sum[48] ? '1 : dl_sum[47:0];
    assign diff      = best_dl_reg - item_reg.now_ms;

    always_comb begin
        if (best_dl_reg <= item_reg.now_ms) begin
            rem = '0;
        end else if (|diff[47:31]) begin
            rem = REM_MAX;
        end else begin
            rem = diff[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_vld_reg   <= 1'b0;
            valid_reg    <= '0;
            rep_reg      <= '0;
            canc_reg     <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= rd_vld_next;
            valid_reg    <= valid_next;
            rep_reg      <= rep_next;
            canc_reg     <= canc_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        full_reg     <= full_next;
        hit_reg      <= hit_next;
        sel_reg      <= sel_next;
        best_dl_reg  <= best_dl_next;
        best_tag_reg <= best_tag_next;
        pend_tag_reg <= pend_tag_next;
        n_reg        <= n_next;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    if (item_reg.action != ACT_EXPIRE) begin
                        state_next = S_IDLE;
                    end else if (!due || (reported && at_limit)) begin
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_FLUSH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        item_next     = item_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        valid_next    = valid_reg;
        rep_next      = rep_reg;
        canc_next     = canc_reg;
        full_next     = full_reg;
        hit_next      = hit_reg;
        sel_next      = sel_reg;
        best_dl_next  = best_dl_reg;
        best_tag_next = best_tag_reg;
        pend_vld_next = pend_vld_reg;
        pend_tag_next = pend_tag_reg;
        n_next        = n_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        res_data      = '0;
        rd_en         = 1'b0;
        rd_addr       = cnt_reg[IW-1:0];
        wr_en         = 1'b0;
        wr_addr       = sel_reg;
        wr_data       = '{deadline: dl_sat, tag: item_reg.tag};

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next     = s_data;
                    cnt_next      = '0;
                    hit_next      = 1'b0;
                    full_next     = &valid_reg;
                    n_next        = '0;
                    pend_vld_next = 1'b0;
                end
            end
            S_SCAN: begin
                rd_en = cnt_reg < (IW+1)'(CAPACITY);
                if (rd_en) begin
                    cnt_next    = cnt_reg + (IW+1)'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[IW-1:0];
                end
                if (rd_vld_reg) begin
                    case (item_reg.action)
                        ACT_ADD: begin
                            if (!valid_reg[rd_idx_reg] && !hit_reg) begin
                                hit_next = 1'b1;
                                sel_next = rd_idx_reg;
                            end
                            // Older timers of the tag lose cancelability only if
                            // the add will succeed.
                            if (valid_reg[rd_idx_reg] && !full_reg &&
                                rd_data.tag == item_reg.tag) begin
                                canc_next[rd_idx_reg] = 1'b0;
                            end
                        end
                        ACT_CANCEL: begin
                            if (!hit_reg && valid_reg[rd_idx_reg] && canc_reg[rd_idx_reg] &&
                                rd_data.tag == item_reg.tag) begin
                                valid_next[rd_idx_reg] = 1'b0;
                                canc_next[rd_idx_reg]  = 1'b0;
                                hit_next               = 1'b1;
                            end
                        end
                        default: begin
                            // Strict compare keeps the lower slot on equal deadlines.
                            if (valid_reg[rd_idx_reg] &&
                                (!hit_reg || rd_data.deadline < best_dl_reg)) begin
                                hit_next      = 1'b1;
                                sel_next      = rd_idx_reg;
                                best_dl_next  = rd_data.deadline;
                                best_tag_next = rd_data.tag;
                            end
                        end
                    endcase
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    case (item_reg.action)
                        ACT_ADD: begin
                            res_valid     = 1'b1;
                            res_data.last = 1'b1;
                            if (hit_reg) begin
                                wr_en               = 1'b1;
                                valid_next[sel_reg] = 1'b1;
                                rep_next[sel_reg]   = item_reg.has_handler;
                                canc_next[sel_reg]  = 1'b1;
                                res_data.status     = ST_ADDED;
                            end else begin
                                res_data.status     = ST_FULL;
                            end
                        end
                        ACT_CANCEL: begin
                            res_valid       = 1'b1;
                            res_data.last   = 1'b1;
                            res_data.status = hit_reg ? ST_CANCELLED : ST_NOT_FOUND;
                        end
                        ACT_QUERY: begin
                            res_valid     = 1'b1;
                            res_data.last = 1'b1;
                            if (hit_reg) begin
                                res_data.status       = ST_NEXT_TIME;
                                res_data.remaining_ms = rem;
                            end else begin
                                res_data.status       = ST_NO_TIMERS;
                            end
                        end
                        default: begin
                            if (due) begin
                                valid_next[sel_reg] = 1'b0;
                                canc_next[sel_reg]  = 1'b0;
                                cnt_next            = '0;
                                hit_next            = 1'b0;
                            end
                            // A reported expiry is held back one step so that the
                            // final one can carry last.
                            if (reported) begin
                                if (pend_vld_reg) begin
                                    res_valid            = 1'b1;
                                    res_data.status      = ST_EXPIRED;
                                    res_data.expired_tag = pend_tag_reg;
                                end
                                pend_vld_next = 1'b1;
                                pend_tag_next = best_tag_reg;
                                n_next        = n_reg + DTQ_NW'(1);
                            end
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                if (res_ready) begin
                    res_valid     = 1'b1;
                    res_data.last = 1'b1;
                    if (pend_vld_reg) begin
                        res_data.status      = ST_EXPIRED;
                        res_data.expired_tag = pend_tag_reg;
                    end else begin
                        res_data.status      = ST_NONE_EXPIRED;
                    end
                    pend_vld_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sim/deadline_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Drives add, cancel, query and expire transfers with random gaps on both
// channels. Every result is checked field by field against an in-bench
// predictor of the slot store, or against the row's own result for typed rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_timer_queue_tb;
    import dtq_pkg::*;

    localparam int    CAP        = DTQ_CAPACITY;
    localparam int    N_RANDOM   = 500;
    localparam int    WDOG_LIMIT = 40000;
    localparam int    DRAIN_WAIT = 2 * (CAP + 3);
    localparam [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        dtq_in_t  item;
        bit       typed;
        dtq_out_t res;
    } stim_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    dtq_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    dtq_out_t m_data;

    deadline_timer_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Model of the slot store.
    logic [47:0] tmr_deadline [CAP];
    logic [15:0] tmr_tag      [CAP];
    bit          tmr_live     [CAP];
    bit          tmr_reports  [CAP];
    bit          tmr_cancel   [CAP];

    dtq_out_t pending_results [$];
    int       err_count;
    int       n_sent;
    int       n_checked;
    int       n_expired;
    int       n_full;
    int       idle_cycles = 0;
    bit       no_gaps;
    logic [47:0] clock_ms;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic int earliest_timer();
        int best;
        best = -1;
        for (int i = 0; i < CAP; i++) begin
            if (tmr_live[i] && (best < 0 || tmr_deadline[i] < tmr_deadline[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic dtq_out_t mk_res(logic [2:0] st, logic [15:0] tg,
                                        logic [30:0] rem, logic lst);
        dtq_out_t r;
        r.status       = st;
        r.expired_tag  = tg;
        r.remaining_ms = rem;
        r.last         = lst;
        return r;
    endfunction

    // Applies one item to the slot model and returns the results it causes.
    task automatic predict_timer_op(input dtq_in_t it, output dtq_out_t res [$]);
        int          slot;
        int          n;
        logic [48:0] sum;
        logic [47:0] diff;
        res = {};
        case (it.action)
            ACT_ADD: begin
                slot = -1;
                for (int i = 0; i < CAP; i++) begin
                    if (!tmr_live[i] && slot < 0)
                        slot = i;
                end
                if (slot < 0) begin
                    res.push_back(mk_res(ST_FULL, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < CAP; i++) begin
                        if (tmr_live[i] && tmr_tag[i] == it.tag)
                            tmr_cancel[i] = 1'b0;
                    end
                    sum = {1'b0, it.now_ms} + {17'd0, it.timeout_ms};
                    tmr_deadline[slot] = sum[48] ? TIME_MAX : sum[47:0];
                    tmr_tag[slot]      = it.tag;
                    tmr_live[slot]     = 1'b1;
                    tmr_reports[slot]  = it.has_handler;
                    tmr_cancel[slot]   = 1'b1;
                    res.push_back(mk_res(ST_ADDED, '0, '0, 1'b1));
                end
            end
            ACT_CANCEL: begin
                slot = -1;
                for (int i = 0; i < CAP; i++) begin
                    if (slot < 0 && tmr_live[i] && tmr_cancel[i] && tmr_tag[i] == it.tag)
                        slot = i;
                end
                if (slot < 0) begin
                    res.push_back(mk_res(ST_NOT_FOUND, '0, '0, 1'b1));
                end else begin
                    tmr_live[slot]   = 1'b0;
                    tmr_cancel[slot] = 1'b0;
                    res.push_back(mk_res(ST_CANCELLED, '0, '0, 1'b1));
                end
            end
            ACT_QUERY: begin
                slot = earliest_timer();
                if (slot < 0) begin
                    res.push_back(mk_res(ST_NO_TIMERS, '0, '0, 1'b1));
                end else begin
                    diff = (tmr_deadline[slot] > it.now_ms) ?
                           tmr_deadline[slot] - it.now_ms : '0;
                    res.push_back(mk_res(ST_NEXT_TIME, '0,
                        (diff > {17'd0, REM_MAX}) ? REM_MAX : diff[30:0], 1'b1));
                end
            end
            default: begin
                n = 0;
                while (n < DTQ_MAX_OUT) begin
                    slot = earliest_timer();
                    if (slot < 0 || tmr_deadline[slot] > it.now_ms)
                        break;
                    tmr_live[slot]   = 1'b0;
                    tmr_cancel[slot] = 1'b0;
                    if (tmr_reports[slot]) begin
                        res.push_back(mk_res(ST_EXPIRED, tmr_tag[slot], '0, 1'b0));
                        n++;
                    end
                end
                if (n == 0)
                    res.push_back(mk_res(ST_NONE_EXPIRED, '0, '0, 1'b1));
                else
                    res[n - 1].last = 1'b1;
            end
        endcase
    endtask

    function automatic int gap_len();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 3);
        return $urandom_range(10, 120);
    endfunction

    // One transfer on the input channel; the prediction is made at the
    // accepting edge. Valid is left high on return, so the caller either
    // sends the next item or idles the channel at that same falling edge.
    task automatic send_item(input dtq_in_t it, input bit typed, input dtq_out_t typed_res);
        dtq_out_t res [$];
        int       gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_timer_op(it, res);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (res[i]) pending_results.push_back(res[i]);
        if (it.action == ACT_ADD && res[0].status == ST_FULL)
            n_full++;
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    function automatic dtq_in_t mk_item(logic [1:0] act, logic [15:0] tg,
                                        logic [31:0] to, logic hh, logic [47:0] now);
        dtq_in_t it;
        it.action      = act;
        it.tag         = tg;
        it.timeout_ms  = to;
        it.has_handler = hh;
        it.now_ms      = now;
        return it;
    endfunction

    function automatic stim_row_t row(logic [1:0] act, logic [15:0] tg, logic [31:0] to,
                                      logic hh, logic [47:0] now, bit typed,
                                      logic [2:0] st, logic [30:0] rem);
        stim_row_t r;
        r.item  = mk_item(act, tg, to, hh, now);
        r.typed = typed;
        r.res   = mk_res(st, '0, rem, 1'b1);
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    // Result channel: random back-pressure, with the odd long stall.
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (!no_gaps && $urandom_range(0, 9) < 3) begin
                m_ready <= 1'b0;
                stall = gap_len();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        dtq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", m_data);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_data.status == ST_EXPIRED)
                    n_expired++;
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    err_count++;
                end
                if (m_data.expired_tag !== want.expired_tag) begin
                    $error("expired_tag: expected %0h, got %0h",
                           want.expired_tag, m_data.expired_tag);
                    err_count++;
                end
                if (m_data.remaining_ms !== want.remaining_ms) begin
                    $error("remaining_ms: expected %0d, got %0d",
                           want.remaining_ms, m_data.remaining_ms);
                    err_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_data.last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
            $display("deadline_timer_queue_tb: done, errors");
            $finish;
        end
    end

    initial begin
        stim_row_t directed [$];
        dtq_out_t  none_res;
        int        pick;
        int        burst;
        logic [15:0] tg;

        err_count   = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_expired   = 0;
        n_full      = 0;
        no_gaps     = 1'b0;
        clock_ms    = 48'd1000;
        none_res    = mk_res(ST_ADDED, '0, '0, 1'b1);
        for (int i = 0; i < CAP; i++) begin
            tmr_deadline[i] = '0;
            tmr_tag[i]      = '0;
            tmr_live[i]     = 1'b0;
            tmr_reports[i]  = 1'b0;
            tmr_cancel[i]   = 1'b0;
        end

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Empty store, saturated deadline, re-add, past-due query, ties.
        directed.push_back(row(ACT_QUERY,  16'h0000, 32'd0, 1'b0, 48'd0, 1'b1,
                               ST_NO_TIMERS, '0));
        directed.push_back(row(ACT_EXPIRE, 16'h0000, 32'd0, 1'b0, TIME_MAX, 1'b1,
                               ST_NONE_EXPIRED, '0));
        directed.push_back(row(ACT_CANCEL, 16'hFFFF, 32'd0, 1'b0, 48'd0, 1'b1,
                               ST_NOT_FOUND, '0));
        directed.push_back(row(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, TIME_MAX, 1'b1,
                               ST_ADDED, '0));
        directed.push_back(row(ACT_QUERY, 16'h0000, 32'd0, 1'b0, 48'd0, 1'b1,
                               ST_NEXT_TIME, REM_MAX));
        directed.push_back(row(ACT_ADD, 16'hFFFF, 32'd0, 1'b1, 48'd0, 1'b1, ST_ADDED, '0));
        directed.push_back(row(ACT_CANCEL, 16'hFFFF, 32'd0, 1'b0, 48'd0, 1'b1,
                               ST_CANCELLED, '0));
        directed.push_back(row(ACT_CANCEL, 16'hFFFF, 32'd0, 1'b0, 48'd0, 1'b1,
                               ST_NOT_FOUND, '0));
        directed.push_back(row(ACT_ADD, 16'h0000, 32'd0, 1'b0, 48'd100, 1'b1, ST_ADDED, '0));
        directed.push_back(row(ACT_ADD, 16'h0001, 32'd5, 1'b1, 48'd100, 1'b1, ST_ADDED, '0));
        directed.push_back(row(ACT_QUERY, 16'h0000, 32'd0, 1'b0, 48'd200, 1'b1,
                               ST_NEXT_TIME, '0));
        directed.push_back(row(ACT_EXPIRE, 16'h0000, 32'd0, 1'b0, 48'd200, 1'b0,
                               ST_ADDED, '0));
        directed.push_back(row(ACT_ADD, 16'h0002, 32'd0, 1'b1, 48'd50, 1'b0, ST_ADDED, '0));
        directed.push_back(row(ACT_ADD, 16'h0003, 32'd0, 1'b1, 48'd50, 1'b0, ST_ADDED, '0));
        directed.push_back(row(ACT_QUERY, 16'h0000, 32'd0, 1'b0, 48'd10, 1'b0,
                               ST_ADDED, '0));
        directed.push_back(row(ACT_EXPIRE, 16'h0000, 32'd0, 1'b0, 48'd50, 1'b0,
                               ST_ADDED, '0));
        directed.push_back(row(ACT_EXPIRE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, TIME_MAX, 1'b0,
                               ST_ADDED, '0));
        directed.push_back(row(ACT_QUERY, 16'h0000, 32'd0, 1'b0, TIME_MAX, 1'b1,
                               ST_NO_TIMERS, '0));
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].res);
        wait_drained();

        while (n_sent < N_RANDOM + directed.size()) begin
            pick    = $urandom_range(0, 19);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (pick < 3) begin
                // Fill past capacity, then expire everything due in one go.
                for (int i = 0; i < CAP + 3; i++) begin
                    send_item(mk_item(ACT_ADD, 16'($urandom_range(0, 31)),
                                      32'($urandom_range(0, 500)),
                                      1'($urandom_range(0, 1)),
                                      clock_ms), 1'b0, none_res);
                end
                clock_ms = clock_ms + $urandom_range(0, 600);
                send_item(mk_item(ACT_EXPIRE, '0, '0, 1'b0, clock_ms), 1'b0, none_res);
                send_item(mk_item(ACT_EXPIRE, '0, '0, 1'b0, clock_ms + 48'd1000), 1'b0,
                          none_res);
                wait_drained();
                repeat (DRAIN_WAIT) @(negedge aclk);
            end else if (pick < 17) begin
                // Session on a running clock with a small tag pool.
                burst = $urandom_range(10, 30);
                for (int i = 0; i < burst; i++) begin
                    clock_ms = clock_ms + $urandom_range(0, 40);
                    tg = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                                                       16'($urandom_range(0, 15));
                    send_item(mk_item(2'($urandom_range(0, 3)), tg,
                                      32'($urandom_range(0, 300)),
                                      1'($urandom_range(0, 1)), clock_ms), 1'b0, none_res);
                end
            end else begin
                // Unrelated items with every field at random over its full range.
                burst = $urandom_range(3, 10);
                for (int i = 0; i < burst; i++) begin
                    send_item(mk_item(2'($urandom_range(0, 3)), 16'($urandom()), $urandom(),
                                      1'($urandom_range(0, 1)), rand48()), 1'b0, none_res);
                end
            end
        end

        no_gaps = 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge aclk);
        $display("sent %0d items, checked %0d results (%0d expiries, %0d adds refused full)",
                 n_sent, n_checked, n_expired, n_full);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("deadline_timer_queue_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     err_count, pending_results.size());
            $display("deadline_timer_queue_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_mem.sv
hw/rtl/dtq_ctrl.sv
hw/rtl/deadline_timer_queue.sv
sim/deadline_timer_queue_tb.sv
